// ===== rtl/core/spq_pkg.sv =====
// shared types and constants of the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PRIO_W   = 16;
	localparam int DATA_W   = 32;
	localparam int OCC_W    = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_PEEK   = 2'd1,
		OP_DELMAX = 2'd2,
		OP_DELMIN = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic signed [PRIO_W-1:0]  prio_in;
		logic signed [DATA_W-1:0]  data_in;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  data_out;
		status_t                   status;
		logic [OCC_W-1:0]          occupancy;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

endpackage

// ===== rtl/core/spq_datapath.sv =====
// entry list, insert/remove logic and result register of the sorted priority queue
`timescale 1ns / 1ps

module spq_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::spq_cmd_t   cmd,
	input  spq_pkg::in_item_t   in_data,
	output spq_pkg::out_item_t  out_data
);

	spq_pkg::in_item_t                       item_q;
	spq_pkg::out_item_t                      res_q;
	logic signed [spq_pkg::PRIO_W-1:0]       prio_q [spq_pkg::CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0]       data_q [spq_pkg::CAPACITY];
	logic [spq_pkg::CNT_W-1:0]               count_q;

	logic signed [spq_pkg::PRIO_W-1:0]       prio_d [spq_pkg::CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0]       data_d [spq_pkg::CAPACITY];
	logic [spq_pkg::CNT_W-1:0]               count_d;
	logic [spq_pkg::CAPACITY-1:0]            ge;
	logic                                    empty;
	logic                                    full;
	logic [spq_pkg::IDX_W-1:0]               tail_idx;
	spq_pkg::out_item_t                      res_d;

	assign empty    = (count_q == '0);
	assign full     = (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
	assign tail_idx = spq_pkg::IDX_W'(count_q - spq_pkg::CNT_W'(1));

	// cells holding an entry that stays ahead of the new one
	always_comb begin
		for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
			ge[i] = (spq_pkg::CNT_W'(i) < count_q) && (prio_q[i] >= item_q.prio_in);
		end
	end

	always_comb begin
		count_d        = count_q;
		res_d.data_out = '0;
		res_d.status   = spq_pkg::ST_OK;
		for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
			prio_d[i] = prio_q[i];
			data_d[i] = data_q[i];
		end
		case (item_q.op)
			spq_pkg::OP_INSERT: begin
				if (full) begin
					res_d.status = spq_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
						if (!ge[i]) begin
							if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
								prio_d[i] = item_q.prio_in;
								data_d[i] = item_q.data_in;
							end else begin
								prio_d[i] = prio_q[(i == 0) ? 0 : i - 1];
								data_d[i] = data_q[(i == 0) ? 0 : i - 1];
							end
						end
					end
					count_d = count_q + spq_pkg::CNT_W'(1);
				end
			end
			spq_pkg::OP_PEEK: begin
				if (empty) begin
					res_d.status = spq_pkg::ST_EMPTY;
				end else begin
					res_d.data_out = data_q[0];
				end
			end
			spq_pkg::OP_DELMAX: begin
				if (empty) begin
					res_d.status = spq_pkg::ST_EMPTY;
				end else begin
					res_d.data_out = data_q[0];
					for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
						prio_d[i] = prio_q[i + 1];
						data_d[i] = data_q[i + 1];
					end
					count_d = count_q - spq_pkg::CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					res_d.status = spq_pkg::ST_EMPTY;
				end else begin
					res_d.data_out = data_q[tail_idx];
					count_d        = count_q - spq_pkg::CNT_W'(1);
				end
			end
		endcase
		res_d.occupancy = spq_pkg::OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			res_q <= res_d;
			for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
				prio_q[i] <= prio_d[i];
				data_q[i] <= data_d[i];
			end
		end
	end

	assign out_data = res_q;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// handshake and sequencing controller of the sorted priority queue
`timescale 1ns / 1ps

module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output spq_pkg::spq_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				// result register must be free before the op commits
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_exec_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || out_ready))
		else $error("op executed while result register still held an item");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted item did not move to execute");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed op produced no result");

	a_exec_not_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !out_valid_q) |-> cmd.exec)
		else $error("execute stalled with free result register");
`endif

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue: up to 16 entries (signed 16-bit priority, 32-bit data) kept in
// descending priority order, equal priorities in arrival order. Each input item is one op
// (insert, peek max, remove max, remove min) and gives exactly one result item with the data
// involved, a status (ok, empty, full) and the occupancy after the op. An item is first
// registered; then the whole entry list compares against it and shifts in parallel and the
// result register is loaded. That second step waits as long as the previous result is still
// held at the output and not taken by the receiver. The next item is accepted as soon as the
// op is done, while its result may still wait at the output. No clearing pass after reset;
// the queue is usable straight out of reset.
`timescale 1ns / 1ps

module sorted_priority_queue_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spq_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spq_pkg::out_item_t  out_data
);

	spq_pkg::spq_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	spq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule
